// ===== sv/changed_pixel_run_finder_unit_assert.svh =====
// Assertion helpers shared by the run finder RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef CHANGED_PIXEL_RUN_FINDER_UNIT_ASSERT_SVH
`define CHANGED_PIXEL_RUN_FINDER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CPRF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CPRF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== sv/cprf_pkg.sv =====
`default_nettype none

package cprf_pkg;

  // Default geometry limits.
  localparam int MAX_COLUMNS_DEF = 256;
  localparam int MAX_ROWS_DEF    = 256;

  // Register widths and reset values.
  localparam int ADDR_W          = 16;
  localparam int GAP_W           = 4;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 16;
  localparam logic [GAP_W-1:0] GAP_LIMIT_RESET = 4'd5;
  localparam logic [GAP_W-1:0] GAP_COUNT_MAX   = 4'd15;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_COLUMN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ROW    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAP_LIMIT   = 2'd2;

  // One pixel pair.
  typedef struct packed {
    logic [15:0] new_color;
    logic [15:0] old_color;
    logic        row_end;
    logic        frame_end;
  } in_item_t;

  // One closed run.
  typedef struct packed {
    logic [15:0] run_row;
    logic [15:0] run_first_column;
    logic [15:0] run_last_column;
    logic        first_in_row;
  } out_item_t;

  // Configuration register values.
  typedef struct packed {
    logic [ADDR_W-1:0] base_column;
    logic [ADDR_W-1:0] base_row;
    logic [GAP_W-1:0]  gap_limit;
  } cfg_t;

  // Result of one tracker step.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

endpackage

`default_nettype wire

// ===== sv/cprf_tracker.sv =====
`default_nettype none

module cprf_tracker #(
  parameter int MAX_COLUMNS = cprf_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = cprf_pkg::MAX_ROWS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire cprf_pkg::in_item_t item,
  input  wire cprf_pkg::cfg_t     cfg,
  output cprf_pkg::step_res_t     res
);

  `include "changed_pixel_run_finder_unit_assert.svh"

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

  logic [COL_W-1:0]          col_r, col_nxt;
  logic [ROW_W-1:0]          row_r, row_nxt;
  logic                      open_r, open_nxt;
  logic [COL_W-1:0]          start_r, start_nxt;
  logic [COL_W-1:0]          last_r, last_nxt;
  logic [cprf_pkg::GAP_W-1:0] cnt_r, cnt_nxt;
  logic                      announced_r, announced_nxt;

  logic                      changed;
  logic                      eol;
  logic                      open_a;
  logic [cprf_pkg::GAP_W-1:0] cnt_a;
  logic                      emit;

  // Pixel classification and run bookkeeping for the current pixel.
  always_comb begin
    changed = (item.new_color != item.old_color);
    eol     = item.row_end || item.frame_end || (col_r == COL_LAST);

    open_a    = open_r || changed;
    start_nxt = (!open_r && changed) ? col_r : start_r;
    last_nxt  = changed ? col_r : last_r;
    if (changed) begin
      cnt_a = '0;
    end else if (open_r && (cnt_r < cprf_pkg::GAP_COUNT_MAX)) begin
      cnt_a = cnt_r + 1'b1;
    end else begin
      cnt_a = cnt_r;
    end

    emit = open_a && ((cnt_a >= cfg.gap_limit) || eol);

    // A closed run clears the run state; a row end clears the row state.
    open_nxt      = open_a && !emit && !eol;
    cnt_nxt       = (emit || eol) ? '0 : cnt_a;
    announced_nxt = eol ? 1'b0 : (announced_r || emit);
    if (eol) begin
      col_nxt = '0;
      row_nxt = (item.frame_end || (row_r == ROW_LAST)) ? '0 : row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
      row_nxt = row_r;
    end
  end

  // Result fields: base offsets added with 16-bit wrap.
  always_comb begin
    res.valid                 = emit;
    res.item.run_row          = cfg.base_row + 16'(row_r);
    res.item.run_first_column = cfg.base_column + 16'(start_nxt);
    res.item.run_last_column  = cfg.base_column + 16'(last_nxt);
    res.item.first_in_row     = !announced_r;
  end

  // Control state advances once per pixel transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      open_r      <= 1'b0;
      start_r     <= '0;
      last_r      <= '0;
      cnt_r       <= '0;
      announced_r <= 1'b0;
    end else if (step) begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      open_r      <= open_nxt;
      start_r     <= start_nxt;
      last_r      <= last_nxt;
      cnt_r       <= cnt_nxt;
      announced_r <= announced_nxt;
    end
  end

  `CPRF_ASSERT_NEXT(a_col_restart, step && eol, col_r == '0 && !open_r && !announced_r)
  `CPRF_ASSERT_NEXT(a_open_on_change, step && changed && !emit && !eol, open_r)
  `CPRF_ASSERT_NEXT(a_announced_after_run, step && emit && !eol, announced_r && !open_r)

endmodule

`default_nettype wire

// ===== sv/changed_pixel_run_finder_unit.sv =====
// Changed-pixel run finder.
// Input channel: in_valid / in_stall / in_item carry one pixel pair (new and
// shown colour) per transfer, in row-major order, with row_end and frame_end
// marks. Output channel: out_valid / out_stall / out_item carry one record per
// closed run: display row, first and last changed column and a first-of-row flag.
// Configuration: cfg_we writes cfg_data into the register selected by cfg_index
// (base column, base row, gap limit); write only while the block is idle.
// Throughput: one pixel per clock cycle, sustained, as long as out_stall is low.
// A record is loaded into the result register when the pixel that closes its run
// moves from the input register to the result.
// The per-pixel compare and counter updates sit between the input register and
// the result register, so a stall on a full result register holds both stages;
// in_stall rises only when the input register holds a pixel and the result
// register is full and stalled.
// Reset (rst_n low at a clock edge) empties both stages, clears the column and
// row counters and any open run, and restores the gap limit to five and the
// base offsets to zero.
`default_nettype none

module changed_pixel_run_finder_unit #(
  parameter int MAX_COLUMNS = cprf_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = cprf_pkg::MAX_ROWS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire cprf_pkg::in_item_t                  in_item,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output cprf_pkg::out_item_t                      out_item,
  input  wire logic                                cfg_we,
  input  wire logic [cprf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [cprf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  `include "changed_pixel_run_finder_unit_assert.svh"

  cprf_pkg::cfg_t      cfg_r;
  logic                s1_valid_r;
  cprf_pkg::in_item_t  s1_item_r;
  logic                out_valid_r;
  cprf_pkg::out_item_t out_item_r;
  logic                s1_go;
  logic                in_take;
  cprf_pkg::step_res_t trk_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_column <= '0;
      cfg_r.base_row    <= '0;
      cfg_r.gap_limit   <= cprf_pkg::GAP_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cprf_pkg::CFG_BASE_COLUMN: cfg_r.base_column <= cfg_data;
        cprf_pkg::CFG_BASE_ROW:    cfg_r.base_row    <= cfg_data;
        cprf_pkg::CFG_GAP_LIMIT:   cfg_r.gap_limit   <= cfg_data[cprf_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input stage moves on when the result register can take it.
  assign s1_go     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_take || (s1_valid_r && !s1_go);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
  end

  // Run tracking for the pixel in the input register.
  cprf_tracker #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_tracker (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_go),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (trk_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= trk_res.valid;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && trk_res.valid) begin
      out_item_r <= trk_res.item;
    end
  end

  `CPRF_ASSERT_SAME(a_stall_only_when_full, in_stall, s1_valid_r && out_valid_r && out_stall)
  `CPRF_ASSERT_NEXT(a_result_loaded, s1_go && trk_res.valid, out_valid_r)
  `CPRF_ASSERT_NEXT(a_no_phantom_result, !s1_go && !out_valid_r, !out_valid_r)

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COL_LAST   = cprf_pkg::MAX_COLUMNS_DEF - 1;
  localparam int ROW_LAST   = cprf_pkg::MAX_ROWS_DEF - 1;
  localparam int DRAIN_WAIT = 4;
  localparam int CYCLE_CAP  = 300000;

  typedef enum {STEP_PIXEL, STEP_CONFIG} step_kind_t;
  typedef enum {CHK_MODEL, CHK_NONE, CHK_RUN} check_kind_t;

  typedef struct {
    step_kind_t          kind;
    cprf_pkg::in_item_t  pixel;
    check_kind_t         chk;
    cprf_pkg::out_item_t run;
    cprf_pkg::cfg_t      cfg;
  } plan_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cprf_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  cprf_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [cprf_pkg::CFG_INDEX_W-1:0] cfg_index = cprf_pkg::CFG_BASE_COLUMN;
  logic [cprf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state, starting from the reset values.
  cprf_pkg::cfg_t cfg_now = '{base_column: 16'h0, base_row: 16'h0,
                              gap_limit: cprf_pkg::GAP_LIMIT_RESET};
  logic [7:0] col_idx = '0;
  logic [7:0] row_idx = '0;
  logic run_open = 1'b0;
  logic [7:0] run_start = '0;
  logic [7:0] last_changed = '0;
  logic [cprf_pkg::GAP_W-1:0] unchanged_cnt = '0;
  logic row_announced = 1'b0;

  cprf_pkg::out_item_t pending_runs[$];
  int errors = 0;
  int cycles = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  changed_pixel_run_finder_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle cycles before a transfer, or stall cycles after a result; none at all while the calm flag is set.
  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic cprf_pkg::in_item_t pair(logic [15:0] nc, logic [15:0] oc, bit re,
                                              bit fe);
    cprf_pkg::in_item_t p;
    p.new_color = nc;
    p.old_color = oc;
    p.row_end = re;
    p.frame_end = fe;
    return p;
  endfunction

  function automatic cprf_pkg::out_item_t run_rec(logic [15:0] r, logic [15:0] f,
                                                  logic [15:0] l, bit fir);
    cprf_pkg::out_item_t o;
    o.run_row = r;
    o.run_first_column = f;
    o.run_last_column = l;
    o.first_in_row = fir;
    return o;
  endfunction

  // Random pixel pair; a changed pixel flips either one bit or a random mask.
  function automatic cprf_pkg::in_item_t make_pixel(bit changed, bit re, bit fe);
    logic [15:0] oc;
    logic [15:0] flip;
    oc = 16'($urandom);
    flip = $urandom_range(0, 1) ? (16'h1 << $urandom_range(0, 15))
                                : 16'($urandom_range(1, 65535));
    return pair(changed ? (oc ^ flip) : oc, oc, re, fe);
  endfunction

  // Steps the run tracker by one pixel and returns 1 when a run closes.
  function automatic bit track_pixel(input cprf_pkg::in_item_t p,
                                     output cprf_pkg::out_item_t run);
    bit eol;
    bit closed;
    eol = p.row_end || p.frame_end || (col_idx == 8'(COL_LAST));
    closed = 1'b0;
    run = '0;
    if (p.new_color != p.old_color) begin
      if (!run_open) begin
        run_open = 1'b1;
        run_start = col_idx;
      end
      last_changed = col_idx;
      unchanged_cnt = '0;
    end else if (run_open && unchanged_cnt != cprf_pkg::GAP_COUNT_MAX) begin
      unchanged_cnt = unchanged_cnt + 1'b1;
    end
    if (run_open && (unchanged_cnt >= cfg_now.gap_limit || eol)) begin
      run.run_row = cfg_now.base_row + 16'(row_idx);
      run.run_first_column = cfg_now.base_column + 16'(run_start);
      run.run_last_column = cfg_now.base_column + 16'(last_changed);
      run.first_in_row = !row_announced;
      row_announced = 1'b1;
      run_open = 1'b0;
      unchanged_cnt = '0;
      closed = 1'b1;
    end
    if (eol) begin
      col_idx = '0;
      row_announced = 1'b0;
      run_open = 1'b0;
      unchanged_cnt = '0;
      row_idx = (p.frame_end || row_idx == 8'(ROW_LAST)) ? 8'h0 : row_idx + 1'b1;
    end else begin
      col_idx = col_idx + 1'b1;
    end
    return closed;
  endfunction

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  // Presents one pixel, holds it until the transfer, then records what it closes.
  task automatic send_pixel(input cprf_pkg::in_item_t p, input check_kind_t chk = CHK_MODEL,
                            input cprf_pkg::out_item_t typed = '0);
    cprf_pkg::out_item_t run;
    bit closed;
    int gap;
    gap = idle_draw();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= p;
    do @(posedge clk); while (in_stall);
    closed = track_pixel(p, run);
    case (chk)
      CHK_MODEL: if (closed) pending_runs.push_back(run);
      CHK_RUN: pending_runs.push_back(typed);
      default: ;
    endcase
  endtask

  // Stops sending and waits until every expected run has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Writes all three registers while the block is idle.
  task automatic set_config(input cprf_pkg::cfg_t c);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= cprf_pkg::CFG_BASE_COLUMN;
    cfg_data <= c.base_column;
    @(posedge clk);
    cfg_index <= cprf_pkg::CFG_BASE_ROW;
    cfg_data <= c.base_row;
    @(posedge clk);
    cfg_index <= cprf_pkg::CFG_GAP_LIMIT;
    cfg_data <= cprf_pkg::CFG_DATA_W'(c.gap_limit);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_now = c;
  endtask

  // Result side: check each transfer against the oldest expected run, then stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_runs.size() == 0) begin
        report("run with nothing expected, row", out_item.run_row, 16'h0);
      end else begin
        if (out_item.run_row != pending_runs[0].run_row)
          report("run_row", out_item.run_row, pending_runs[0].run_row);
        if (out_item.run_first_column != pending_runs[0].run_first_column)
          report("run_first_column", out_item.run_first_column,
                 pending_runs[0].run_first_column);
        if (out_item.run_last_column != pending_runs[0].run_last_column)
          report("run_last_column", out_item.run_last_column,
                 pending_runs[0].run_last_column);
        if (out_item.first_in_row != pending_runs[0].first_in_row)
          report("first_in_row", 16'(out_item.first_in_row),
                 16'(pending_runs[0].first_in_row));
        void'(pending_runs.pop_front());
      end
      stall_left = idle_draw();
    end else if (stall_left != 0) begin
      stall_left--;
    end
    out_stall <= (stall_left != 0);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    plan_row_t plan[$];
    cprf_pkg::cfg_t c;
    cprf_pkg::in_item_t p;
    int len;
    int density;
    int sent;
    bit noisy;
    bit fe;

    // Directed rows; the first rows run with the reset configuration.
    plan.push_back('{STEP_PIXEL, pair(16'h0000, 16'h0000, 0, 0), CHK_NONE, '0, '0});
    plan.push_back('{STEP_PIXEL, pair(16'hFFFF, 16'h0000, 0, 0), CHK_NONE, '0, '0});
    repeat (4)
      plan.push_back('{STEP_PIXEL, pair(16'h5555, 16'h5555, 0, 0), CHK_NONE, '0, '0});
    // Fifth unchanged pixel closes the run at the default gap limit.
    plan.push_back('{STEP_PIXEL, pair(16'h5555, 16'h5555, 0, 0), CHK_RUN,
                     run_rec(16'h0, 16'h1, 16'h1, 1), '0});
    plan.push_back('{STEP_PIXEL, pair(16'hFFFF, 16'hFFFF, 0, 0), CHK_NONE, '0, '0});
    // A change on the row's last pixel closes at once.
    plan.push_back('{STEP_PIXEL, pair(16'h1234, 16'h1235, 1, 0), CHK_RUN,
                     run_rec(16'h0, 16'h8, 16'h8, 0), '0});
    // Frame end alone also ends the row.
    plan.push_back('{STEP_PIXEL, pair(16'h0000, 16'hFFFF, 0, 1), CHK_RUN,
                     run_rec(16'h1, 16'h0, 16'h0, 1), '0});
    plan.push_back('{STEP_PIXEL, pair(16'hABCD, 16'hABCD, 1, 1), CHK_NONE, '0, '0});
    // Zero gap limit with offsets that wrap.
    plan.push_back('{STEP_CONFIG, '0, CHK_NONE, '0,
                     cprf_pkg::cfg_t'{16'hFFFE, 16'hFFFF, 4'd0}});
    plan.push_back('{STEP_PIXEL, pair(16'h0001, 16'h0000, 0, 0), CHK_RUN,
                     run_rec(16'hFFFF, 16'hFFFE, 16'hFFFE, 1), '0});
    plan.push_back('{STEP_PIXEL, pair(16'h8000, 16'h0000, 0, 0), CHK_RUN,
                     run_rec(16'hFFFF, 16'hFFFF, 16'hFFFF, 0), '0});
    plan.push_back('{STEP_PIXEL, pair(16'hFFFF, 16'h7FFF, 1, 0), CHK_RUN,
                     run_rec(16'hFFFF, 16'h0000, 16'h0000, 0), '0});
    plan.push_back('{STEP_PIXEL, pair(16'h0000, 16'h0000, 1, 0), CHK_NONE, '0, '0});
    plan.push_back('{STEP_PIXEL, pair(16'hC3C3, 16'h3C3C, 0, 1), CHK_RUN,
                     run_rec(16'h0001, 16'hFFFE, 16'hFFFE, 1), '0});
    // Largest gap limit; the predictor follows from here.
    plan.push_back('{STEP_CONFIG, '0, CHK_NONE, '0,
                     cprf_pkg::cfg_t'{16'h0100, 16'h0010, 4'd15}});
    plan.push_back('{STEP_PIXEL, pair(16'h0F0F, 16'hF0F0, 0, 0), CHK_MODEL, '0, '0});
    repeat (3)
      plan.push_back('{STEP_PIXEL, pair(16'h2468, 16'h2468, 0, 0), CHK_MODEL, '0, '0});
    plan.push_back('{STEP_PIXEL, pair(16'h7FFF, 16'hFFFF, 0, 0), CHK_MODEL, '0, '0});
    plan.push_back('{STEP_PIXEL, pair(16'h1111, 16'h1111, 1, 0), CHK_MODEL, '0, '0});
    plan.push_back('{STEP_PIXEL, pair(16'hFFFE, 16'h0001, 1, 1), CHK_MODEL, '0, '0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].kind == STEP_CONFIG)
        set_config(plan[k].cfg);
      else
        send_pixel(plan[k].pixel, plan[k].chk, plan[k].run);
    end

    // An unmarked row runs into the column limit, with changes on its last columns.
    calm = 1'b1;
    set_config(cprf_pkg::cfg_t'{16'h0040, 16'h0000, 4'd3});
    for (int i = 0; i < 260; i++)
      send_pixel(make_pixel(i == 254 || i == 255 || $urandom_range(0, 9) == 0, 0, 0));

    // Random rows under several settings; a few rows carry marks at random.
    for (int ph = 0; ph < 5; ph++) begin
      c.base_column = (ph == 1) ? 16'hFFFF : 16'($urandom);
      c.base_row = (ph == 0) ? 16'hFFF8 : 16'($urandom);
      c.gap_limit = (ph == 0) ? 4'd1 : (ph == 1) ? 4'd15 : 4'($urandom_range(0, 15));
      calm = (ph == 3);
      set_config(c);
      sent = 0;
      while (sent < 20) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
        density = $urandom_range(0, 60);
        noisy = ($urandom_range(0, 9) == 0);
        fe = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++) begin
          if (noisy)
            p = make_pixel($urandom_range(0, 99) < density, $urandom_range(0, 7) == 0,
                           $urandom_range(0, 15) == 0);
          else
            p = make_pixel($urandom_range(0, 99) < density, i == len - 1,
                           (i == len - 1) && fe);
          send_pixel(p);
        end
        sent += len;
      end
    end

    drain();
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/cprf_pkg.sv
sv/cprf_tracker.sv
sv/changed_pixel_run_finder_unit.sv
sim/tb_top.sv
